// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/led_pkg.sv =====
package led_pkg;

   // result kinds, carried on rsp_tuser
   typedef enum logic [1:0] {
      KIND_ECHO = 2'd0,
      KIND_CHAR = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_END_CHAR  = 2'd0,
      REG_ERASE_A   = 2'd1,
      REG_ERASE_B   = 2'd2,
      REG_LINE_SIZE = 2'd3
   } reg_index_type;

   localparam int CHAR_W = 8;
   localparam int POS_W  = 5;
   localparam int SIZE_W = 6;

   localparam logic [CHAR_W-1:0] CODE_BS = 8'h08;
   localparam logic [CHAR_W-1:0] CODE_SP = 8'h20;
   localparam logic [CHAR_W-1:0] CODE_CR = 8'h0D;
   localparam logic [CHAR_W-1:0] CODE_LF = 8'h0A;
   localparam logic [CHAR_W-1:0] CODE_NUL = 8'h00;

   localparam logic [CHAR_W-1:0] END_CHAR_RST  = 8'd13;
   localparam logic [CHAR_W-1:0] ERASE_A_RST   = 8'd8;
   localparam logic [CHAR_W-1:0] ERASE_B_RST   = 8'd127;
   localparam logic [SIZE_W-1:0] LINE_SIZE_RST = 6'd32;
   localparam logic [SIZE_W-1:0] LINE_SIZE_MIN = 6'd2;

   // payload of one result beat, char_value in the lowest bits
   typedef struct packed {
      logic                truncated;
      logic [POS_W-1:0]    line_length;
      logic [POS_W-1:0]    position;
      logic [CHAR_W-1:0]   char_value;
   } rsp_data_type;

endpackage

// ===== hdl/led_ram.sv =====
module led_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/line_editor_with_echo.sv =====
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | req_tdata[7:0] rx_char
// rsp     | out | rsp_tvalid/rsp_tready | tdata char/pos/len/trunc, tuser kind, tlast last
// csr     | in  | csr_valid/csr_ready   | csr_index register, csr_wdata value
//
// one character at a time: a small sequencer steps a single shared 8-bit
// comparator through erase a, erase b, end char and carriage return.
// line completion reads the line store one entry at a time (read, then
// emit) and closes with the done beat.
// reset is synchronous, active high; the line store has no reset and is
// only read below the fill count. rsp stalls hold the sequencer in place.
`include "assert_macros.svh"

module line_editor_with_echo #(
   parameter int LINE_MAX = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_char

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] char_value, [12:8] position,
                                    // [17:13] line_length, [18] truncated
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // last

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int CNT_W = $clog2(LINE_MAX);
   localparam int CW    = led_pkg::CHAR_W;
   localparam int SW    = led_pkg::SIZE_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CMP_A,
      S_CMP_B,
      S_CMP_E,
      S_ERASE,
      S_BS1,
      S_SP,
      S_BS2,
      S_ECHO_CH,
      S_ECHO_LF,
      S_RD,
      S_CHR,
      S_DONE
   } state_type;

   // configuration registers
   logic [CW-1:0] end_char_ff;
   logic [CW-1:0] erase_a_ff;
   logic [CW-1:0] erase_b_ff;
   logic [SW-1:0] line_size_ff;

   // sequencer state
   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CW-1:0]   char_ff, char_in;
   logic            is_end_ff, is_end_in;
   logic            trunc_ff, trunc_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   led_pkg::rsp_data_type rsp_data_ff, rsp_data_in;
   led_pkg::kind_type    rsp_kind_ff, rsp_kind_in;
   logic                 rsp_last_ff, rsp_last_in;

   // shared comparator
   logic [CW-1:0] cmp_operand;
   logic          cmp_eq;

   // line store port
   logic          ram_we;
   logic          ram_re;
   logic [CW-1:0] ram_rdata;

   logic [SW-1:0] size_eff;
   logic [SW-1:0] cap;
   logic          room;
   logic          free;
   logic          emit;

   // clamp line_size into [2, LINE_MAX]; capacity is one less
   always_comb begin
      if (line_size_ff < led_pkg::LINE_SIZE_MIN) begin
         size_eff = led_pkg::LINE_SIZE_MIN;
      end else if (line_size_ff > SW'(LINE_MAX)) begin
         size_eff = SW'(LINE_MAX);
      end else begin
         size_eff = line_size_ff;
      end
   end

   assign cap  = size_eff - SW'(1);
   assign room = (7'(count_ff) < 7'(cap));

   // one comparator, its operand chosen by the sequencer step
   always_comb begin
      case (state_ff)
         S_CMP_A: cmp_operand = erase_a_ff;
         S_CMP_B: cmp_operand = erase_b_ff;
         S_CMP_E: cmp_operand = end_char_ff;
         default: cmp_operand = led_pkg::CODE_CR;
      endcase
   end

   assign cmp_eq = (char_ff == cmp_operand);

   // output register can take a beat when empty or being drained
   assign free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      char_in      = char_ff;
      is_end_in    = is_end_ff;
      trunc_in     = trunc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      emit         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               char_in  = req_tdata;
               state_in = S_CMP_A;
            end
         end
         // erase codes take precedence over the end code
         S_CMP_A: begin
            state_in = cmp_eq ? S_ERASE : S_CMP_B;
         end
         S_CMP_B: begin
            state_in = cmp_eq ? S_ERASE : S_CMP_E;
         end
         S_CMP_E: begin
            is_end_in = cmp_eq;
            trunc_in  = !cmp_eq && !room;
            state_in  = S_ECHO_CH;
         end
         // erase on an empty line gives no beat at all
         S_ERASE: begin
            state_in = (count_ff == '0) ? S_IDLE : S_BS1;
         end
         S_BS1: begin
            if (free) begin
               emit                   = 1'b1;
               rsp_kind_in            = led_pkg::KIND_ECHO;
               rsp_data_in            = '0;
               rsp_data_in.char_value = led_pkg::CODE_BS;
               rsp_last_in            = 1'b0;
               state_in               = S_SP;
            end
         end
         S_SP: begin
            if (free) begin
               emit                   = 1'b1;
               rsp_kind_in            = led_pkg::KIND_ECHO;
               rsp_data_in            = '0;
               rsp_data_in.char_value = led_pkg::CODE_SP;
               rsp_last_in            = 1'b0;
               state_in               = S_BS2;
            end
         end
         S_BS2: begin
            if (free) begin
               emit                   = 1'b1;
               rsp_kind_in            = led_pkg::KIND_ECHO;
               rsp_data_in            = '0;
               rsp_data_in.char_value = led_pkg::CODE_BS;
               rsp_last_in            = 1'b1;
               count_in               = count_ff - CNT_W'(1);
               state_in               = S_IDLE;
            end
         end
         // comparator checks for carriage return here
         S_ECHO_CH: begin
            if (free) begin
               emit                   = 1'b1;
               rsp_kind_in            = led_pkg::KIND_ECHO;
               rsp_data_in            = '0;
               rsp_data_in.char_value = char_ff;
               idx_in                 = '0;
               if (is_end_ff) begin
                  rsp_last_in = 1'b0;
                  state_in    = cmp_eq ? S_ECHO_LF : S_RD;
               end else if (trunc_ff) begin
                  rsp_last_in = 1'b0;
                  state_in    = S_RD;
               end else begin
                  rsp_last_in = 1'b1;
                  ram_we      = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
                  state_in    = S_IDLE;
               end
            end
         end
         S_ECHO_LF: begin
            if (free) begin
               emit                   = 1'b1;
               rsp_kind_in            = led_pkg::KIND_ECHO;
               rsp_data_in            = '0;
               rsp_data_in.char_value = led_pkg::CODE_LF;
               rsp_last_in            = 1'b0;
               state_in               = S_RD;
            end
         end
         S_RD: begin
            if (idx_ff == count_ff) begin
               state_in = S_DONE;
            end else begin
               ram_re   = 1'b1;
               state_in = S_CHR;
            end
         end
         S_CHR: begin
            if (free) begin
               emit                   = 1'b1;
               rsp_kind_in            = led_pkg::KIND_CHAR;
               rsp_data_in            = '0;
               rsp_data_in.char_value = ram_rdata;
               rsp_data_in.position   = led_pkg::POS_W'(idx_ff);
               rsp_last_in            = 1'b0;
               idx_in                 = idx_ff + CNT_W'(1);
               state_in               = S_RD;
            end
         end
         S_DONE: begin
            if (free) begin
               emit                    = 1'b1;
               rsp_kind_in             = led_pkg::KIND_DONE;
               rsp_data_in             = '0;
               rsp_data_in.char_value  = led_pkg::CODE_NUL;
               rsp_data_in.line_length = led_pkg::POS_W'(count_ff);
               rsp_data_in.truncated   = trunc_ff;
               rsp_last_in             = 1'b1;
               count_in                = '0;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         end_char_ff  <= led_pkg::END_CHAR_RST;
         erase_a_ff   <= led_pkg::ERASE_A_RST;
         erase_b_ff   <= led_pkg::ERASE_B_RST;
         line_size_ff <= led_pkg::LINE_SIZE_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         // register writes, any index beyond the list is dropped
         if (csr_valid) begin
            case (csr_index)
               led_pkg::REG_END_CHAR:  end_char_ff  <= csr_wdata;
               led_pkg::REG_ERASE_A:   erase_a_ff   <= csr_wdata;
               led_pkg::REG_ERASE_B:   erase_b_ff   <= csr_wdata;
               led_pkg::REG_LINE_SIZE: line_size_ff <= csr_wdata[SW-1:0];
               default: ;
            endcase
         end
      end
      idx_ff      <= idx_in;
      char_ff     <= char_in;
      is_end_ff   <= is_end_in;
      trunc_ff    <= trunc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   // line store, written at the fill count and read during completion
   led_ram #(
      .WIDTH (CW),
      .DEPTH (LINE_MAX)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff),
      .wr_data (char_ff),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 24'(rsp_data_ff);
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a new beat never overwrites one that is still waiting
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, emit, !rsp_valid_ff || rsp_tready)
   // stores only happen while the line has room
   `ASSERT_IMPLIES(a_store_room, clock, reset, ram_we, room)
   // a line character beat always lies inside the stored line
   `ASSERT_IMPLIES(a_chr_in_line, clock, reset, state_ff == S_CHR, idx_ff < count_ff)
   // a line-complete beat always closes the item's results
   `ASSERT_IMPLIES(a_done_last, clock, reset, rsp_valid_ff && rsp_kind_ff == led_pkg::KIND_DONE, rsp_last_ff)
   // after completion the line restarts empty
   `ASSERT_NEXT(a_done_clears, clock, reset, state_ff == S_DONE && free, count_ff == '0)

endmodule

// ===== dv/tb_line_editor_with_echo.sv =====
`timescale 1ns / 1ps

module tb_line_editor_with_echo;

   localparam int LINE_MAX    = 32;
   localparam int SETTLE      = 24;      // covers an erase on an empty line, which emits nothing
   localparam int CYCLE_LIMIT = 400000;

   // one expected output beat of the editor
   typedef struct {
      led_pkg::kind_type          kind;
      logic [led_pkg::CHAR_W-1:0] char_value;
      logic [led_pkg::POS_W-1:0]  position;
      logic [led_pkg::POS_W-1:0]  line_length;
      logic                       truncated;
      logic                       last;
   } editor_beat_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   led_pkg::reg_index_type csr_index  = led_pkg::REG_END_CHAR;
   logic [7:0]             csr_wdata  = '0;

   // mirror of the editor: its registers, line store and fill count
   logic [led_pkg::CHAR_W-1:0] end_code;
   logic [led_pkg::CHAR_W-1:0] erase_code_a;
   logic [led_pkg::CHAR_W-1:0] erase_code_b;
   logic [led_pkg::SIZE_W-1:0] size_reg;
   logic [led_pkg::CHAR_W-1:0] line_buf [LINE_MAX];
   int                         line_fill;

   editor_beat_type   pending_output [$];
   int                err_count    = 0;
   int                cycle_count  = 0;
   int                rsp_hold_req = 0;     // long receiver hold-off, in cycles
   bit                steady       = 1'b0;  // no idling on either side while set

   line_editor_with_echo #(
      .LINE_MAX(LINE_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // line editing prediction
   // ---------------------------------------------------------------------

   // characters the store may hold; out-of-range sizes clamp to 2 and LINE_MAX
   function automatic int line_room();
      int size;
      size = size_reg;
      if (size < led_pkg::LINE_SIZE_MIN) size = led_pkg::LINE_SIZE_MIN;
      if (size > LINE_MAX) size = LINE_MAX;
      return size - 1;
   endfunction

   function automatic void queue_beat(led_pkg::kind_type kind,
                                      logic [led_pkg::CHAR_W-1:0] ch, int pos, int len,
                                      logic trunc);
      editor_beat_type b;
      b.kind        = kind;
      b.char_value  = ch;
      b.position    = led_pkg::POS_W'(pos);
      b.line_length = led_pkg::POS_W'(len);
      b.truncated   = trunc;
      b.last        = 1'b0;
      pending_output.push_back(b);
   endfunction

   // works out every beat one received character causes
   function automatic void edit_char(logic [led_pkg::CHAR_W-1:0] c);
      int first;
      int i;
      bit close_line;
      bit trunc;
      first      = pending_output.size();
      close_line = 1'b0;
      trunc      = 1'b0;
      // erase wins over end when the codes coincide
      if (c == erase_code_a || c == erase_code_b) begin
         if (line_fill > 0) begin
            // a plain backspace is echoed whatever the erase codes are
            queue_beat(led_pkg::KIND_ECHO, led_pkg::CODE_BS, 0, 0, 1'b0);
            queue_beat(led_pkg::KIND_ECHO, led_pkg::CODE_SP, 0, 0, 1'b0);
            queue_beat(led_pkg::KIND_ECHO, led_pkg::CODE_BS, 0, 0, 1'b0);
            line_fill--;
         end
      end else if (c == end_code) begin
         queue_beat(led_pkg::KIND_ECHO, c, 0, 0, 1'b0);
         if (c == led_pkg::CODE_CR)
            queue_beat(led_pkg::KIND_ECHO, led_pkg::CODE_LF, 0, 0, 1'b0);
         close_line = 1'b1;
      end else begin
         queue_beat(led_pkg::KIND_ECHO, c, 0, 0, 1'b0);
         // a lowered size keeps what is stored; the next char then ends the line
         if (line_fill < line_room()) begin
            line_buf[line_fill] = c;
            line_fill++;
         end else begin
            close_line = 1'b1;
            trunc      = 1'b1;
         end
      end
      if (close_line) begin
         for (i = 0; i < line_fill; i++)
            queue_beat(led_pkg::KIND_CHAR, line_buf[i], i, 0, 1'b0);
         queue_beat(led_pkg::KIND_DONE, led_pkg::CODE_NUL, 0, line_fill, trunc);
         line_fill = 0;
      end
      if (pending_output.size() > first)
         pending_output[pending_output.size() - 1].last = 1'b1;
   endfunction

   function automatic void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         err_count++;
      end
   endfunction

   // watches all three channels: csr beats update the mirror, req beats are
   // predicted, rsp beats are checked against the oldest prediction
   always @(posedge clock) begin : output_monitor
      editor_beat_type       want;
      led_pkg::rsp_data_type got;
      if (reset) begin
         end_code     = led_pkg::END_CHAR_RST;
         erase_code_a = led_pkg::ERASE_A_RST;
         erase_code_b = led_pkg::ERASE_B_RST;
         size_reg     = led_pkg::LINE_SIZE_RST;
         line_fill    = 0;
         pending_output.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               led_pkg::REG_END_CHAR:  end_code     = csr_wdata;
               led_pkg::REG_ERASE_A:   erase_code_a = csr_wdata;
               led_pkg::REG_ERASE_B:   erase_code_b = csr_wdata;
               led_pkg::REG_LINE_SIZE: size_reg     = csr_wdata[led_pkg::SIZE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) edit_char(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_output.size() == 0) begin
               $error("unexpected beat: kind %0d, char %0h", rsp_tuser, rsp_tdata[7:0]);
               err_count++;
            end else begin
               want = pending_output.pop_front();
               got  = rsp_tdata[$bits(led_pkg::rsp_data_type)-1:0];
               field_check("kind", want.kind, rsp_tuser);
               field_check("char_value", want.char_value, got.char_value);
               field_check("position", want.position, got.position);
               field_check("line_length", want.line_length, got.line_length);
               field_check("truncated", want.truncated, got.truncated);
               field_check("last", want.last, rsp_tlast);
            end
         end
      end
   end

   // receiver pacing: random stalls, plus a long hold-off counted here on request
   always @(posedge clock) begin : rsp_pacing
      int hold_left = 0;
      if (rsp_hold_req > 0) begin
         hold_left    = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 15);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_line_editor_with_echo: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // leaves req_tvalid high after the beat, so back-to-back chars never
   // drop and raise it in the same step
   task automatic send_char(input logic [7:0] c);
      while (!steady && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
   endtask

   // sender pauses until every predicted beat is out and the editor is quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_output.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input led_pkg::reg_index_type idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);   // lets the mirror take the new value
   endtask

   task automatic configure(input logic [7:0] end_c, input logic [7:0] era_a,
                            input logic [7:0] era_b, input logic [7:0] size);
      settle();
      write_reg(led_pkg::REG_END_CHAR, end_c);
      write_reg(led_pkg::REG_ERASE_A, era_a);
      write_reg(led_pkg::REG_ERASE_B, era_b);
      write_reg(led_pkg::REG_LINE_SIZE, size);
   endtask

   // a byte the editor stores as text under the current codes
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == end_code || c == erase_code_a || c == erase_code_b);
      return c;
   endfunction

   // mostly well-formed lines with random text, some erases and noise,
   // now and then a line that runs past the store
   task automatic send_lines(input int n_items);
      int sent;
      int len;
      int k;
      int roll;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) len = line_room() + $urandom_range(1, 3);
         else len = $urandom_range(0, line_room());
         for (k = 0; k < len; k++) begin
            roll = $urandom_range(99);
            if (roll < 8) send_char(erase_code_a);
            else if (roll < 14) send_char(erase_code_b);
            else if (roll < 18) send_char(8'($urandom_range(255)));
            else send_char(plain_char());
            sent++;
         end
         if ($urandom_range(9) != 0) begin
            send_char(end_code);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset codes: erase on empty line, extreme bytes, both erase codes, CR end
   task automatic test_basic_editing();
      configure(led_pkg::END_CHAR_RST, led_pkg::ERASE_A_RST, led_pkg::ERASE_B_RST,
                led_pkg::LINE_SIZE_RST);
      send_char(led_pkg::ERASE_A_RST);
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h55);
      send_char(8'hAA);
      send_char(led_pkg::ERASE_A_RST);
      send_char(led_pkg::ERASE_B_RST);
      send_char(led_pkg::CODE_CR);
   endtask

   // smallest store, and a size below the minimum that must act as 2
   task automatic test_truncation();
      configure(led_pkg::END_CHAR_RST, led_pkg::ERASE_A_RST, led_pkg::ERASE_B_RST, 8'd2);
      send_char(8'h78);
      send_char(8'h79);
      configure(led_pkg::END_CHAR_RST, led_pkg::ERASE_A_RST, led_pkg::ERASE_B_RST, 8'd0);
      send_char(8'h70);
      send_char(8'h71);
   endtask

   // erase code equal to end code, non-standard erase code, end code other than CR
   task automatic test_code_overlap();
      configure(8'h41, 8'h41, 8'h7E, led_pkg::LINE_SIZE_RST);
      send_char(8'h62);
      send_char(8'h41);
      send_char(8'h7E);
      configure(led_pkg::CODE_LF, 8'h41, 8'h7E, led_pkg::LINE_SIZE_RST);
      send_char(8'h64);
      send_char(8'h7E);
      send_char(8'h65);
      send_char(led_pkg::CODE_LF);
   endtask

   // store shrinks under a partial line: next char ends it with all it holds
   task automatic test_size_lowered();
      int k;
      configure(led_pkg::END_CHAR_RST, led_pkg::ERASE_A_RST, led_pkg::ERASE_B_RST,
                led_pkg::LINE_SIZE_RST);
      for (k = 0; k < 5; k++) send_char(plain_char());
      settle();
      write_reg(led_pkg::REG_LINE_SIZE, 8'd3);
      send_char(plain_char());
   endtask

   // receiver holds off long enough for the editor to back up into req
   task automatic test_backpressure();
      configure(led_pkg::END_CHAR_RST, led_pkg::ERASE_A_RST, led_pkg::ERASE_B_RST, 8'd5);
      rsp_hold_req = 400;
      send_lines(40);
      settle();
   endtask

   task automatic test_random_lines();
      int k;
      steady = 1'b1;
      configure(led_pkg::END_CHAR_RST, led_pkg::ERASE_A_RST, led_pkg::ERASE_B_RST,
                led_pkg::LINE_SIZE_RST);
      send_lines(50);
      settle();
      steady = 1'b0;
      configure(8'h00, 8'hFF, 8'h01, 8'd2);
      send_lines(30);
      configure(8'hFF, 8'h00, 8'h7F, 8'd63);
      send_lines(50);
      configure(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)), 8'd1);
      send_lines(20);
      for (k = 0; k < 3; k++) begin
         configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(3, 31)));
         send_lines(25);
      end
      configure(led_pkg::CODE_LF, 8'h7F, 8'h08, 8'd33);
      send_lines(25);
   endtask

   initial begin : main
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_basic_editing();
      test_truncation();
      test_code_overlap();
      test_size_lowered();
      test_backpressure();
      test_random_lines();
      settle();
      if (err_count == 0) begin
         $display("tb_line_editor_with_echo: done, clean");
      end else begin
         $display("tb_line_editor_with_echo: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/led_pkg.sv
hdl/led_ram.sv
hdl/line_editor_with_echo.sv
dv/tb_line_editor_with_echo.sv
